@@ rtl/lowbit_element_pack_unpack_top_defines.svh @@
// Assertion macros for the low-bit pack/unpack block.
// Taken in by the port checker; depends on clk_i and rst_ni in the including scope.
`ifndef LOWBIT_ELEMENT_PACK_UNPACK_TOP_DEFINES_SVH
`define LOWBIT_ELEMENT_PACK_UNPACK_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LBPK_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define LBPK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lbpk_pkg.sv @@
// Shared types, codes and element codec functions for the low-bit pack/unpack block.
// No dependencies; imported by every module of the block.
package lbpk_pkg;

  localparam int ByteW  = 8;
  localparam int CountW = 4;
  localparam int FmtW   = 3;
  localparam int SlotW  = 3;
  localparam int TdataW = 16;
  localparam int TuserW = 2;

  // Positions of the result flags inside m_axis_tuser
  localparam int UserRunEnd = 0;
  localparam int UserErr    = 1;

  typedef enum logic [FmtW-1:0] {
    FMT_ODD1 = 3'd0,
    FMT_ODD2 = 3'd1,
    FMT_ODD4 = 3'd2,
    FMT_UQ4  = 3'd3,
    FMT_SQ4  = 3'd4
  } fmt_e;

  typedef enum logic {
    DIR_PACK   = 1'b0,
    DIR_UNPACK = 1'b1
  } dir_e;

  typedef enum logic {
    REG_FORMAT    = 1'b0,
    REG_DIRECTION = 1'b1
  } reg_idx_e;

  // Item held for processing
  typedef struct packed {
    logic [ByteW-1:0]  byte_v;
    logic              last;
    logic [CountW-1:0] count;
    logic [SlotW-1:0]  k;
  } item_t;

  // Pack-side state carried between items
  typedef struct packed {
    logic [ByteW-1:0] acc;
    logic [SlotW-1:0] slot;
    logic             err;
  } pack_st_t;

  // One step of work on the held item
  typedef struct packed {
    logic             emit;
    logic             done;
    logic [ByteW-1:0] data;
    logic             run_end;
    logic             last;
    logic             err;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] code;
  } enc_t;

  // log2 of the field width: 1, 2 or 4 bits
  function automatic logic [1:0] fmt_log2bits(logic [FmtW-1:0] fmt);
    case (fmt)
      FMT_ODD2:                   fmt_log2bits = 2'd1;
      FMT_ODD4, FMT_UQ4, FMT_SQ4: fmt_log2bits = 2'd2;
      default:                    fmt_log2bits = 2'd0;
    endcase
  endfunction

  function automatic logic [4:0] fmt_shift(logic [FmtW-1:0] fmt);
    case (fmt)
      FMT_ODD2: fmt_shift = 5'd3;
      FMT_ODD4: fmt_shift = 5'd15;
      FMT_UQ4:  fmt_shift = 5'd0;
      FMT_SQ4:  fmt_shift = 5'd8;
      default:  fmt_shift = 5'd1;
    endcase
  endfunction

  function automatic logic fmt_odd(logic [FmtW-1:0] fmt);
    fmt_odd = !((fmt == FMT_UQ4) || (fmt == FMT_SQ4));
  endfunction

  // Fields per byte: 8, 4 or 2
  function automatic logic [CountW-1:0] fmt_slots(logic [FmtW-1:0] fmt);
    fmt_slots = CountW'(4'd8 >> fmt_log2bits(fmt));
  endfunction

  // Encode one element; ok low when the value has no code in the format
  function automatic enc_t encode(logic [FmtW-1:0] fmt, logic [ByteW-1:0] v);
    logic [9:0] t;
    logic [8:0] h;
    logic [3:0] nbits;
    logic       fits;
    enc_t       r;
    t     = {{2{v[7]}}, v} + {5'd0, fmt_shift(fmt)};
    h     = fmt_odd(fmt) ? t[9:1] : t[8:0];
    nbits = 4'd1 << fmt_log2bits(fmt);
    fits  = (h >> nbits) == 9'd0;
    r.ok   = !t[9] && (!fmt_odd(fmt) || !t[0]) && fits;
    r.code = r.ok ? h[3:0] : 4'd0;
    encode = r;
  endfunction

  // Expand one code back to a two's complement element
  function automatic logic [ByteW-1:0] decode(logic [FmtW-1:0] fmt, logic [3:0] code);
    if (fmt_odd(fmt)) begin
      decode = {3'd0, code, 1'b0} - {3'd0, fmt_shift(fmt)};
    end else begin
      decode = {4'd0, code} - {3'd0, fmt_shift(fmt)};
    end
  endfunction

endpackage

@@ rtl/lowbit_element_pack_unpack_top.sv @@
// Top level of the low-bit element pack/unpack block.
// Depends on lbpk_pkg and lbpk_step.
//
// Usage:
//   Input stream (s_axis): tdata carries byte_in in [7:0] and unpack_count in
//   [11:8]; tlast carries last_in. Output stream (m_axis): tdata carries
//   byte_out, tlast carries last_out, tuser carries run_end and error.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 element format, 1 direction); a write drops any partly packed byte.
//   Write configuration only while no transaction is in flight.
//   An input is held in the holding register and the result it completes is
//   registered in the result register. Pack mode takes one element per cycle
//   while the receiver does not stall and emits a byte when full or at last_in.
//   In unpack mode a byte occupies the holding register until the single result
//   register has emitted its unpack_count (clamped) elements, one per cycle while
//   the receiver is ready. A new input transaction is taken in the cycle the held
//   item finishes. Reset clears the format, direction, pack state and both valid
//   flags. When the receiver stalls the result register holds its contents and
//   the block stops taking input once the holding register is blocked.
module lowbit_element_pack_unpack_top
  import lbpk_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write port
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [FmtW-1:0]   cfg_data_i,
  // Input stream
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [TdataW-1:0] s_axis_tdata_i,   // [7:0] byte_in, [11:8] unpack_count, rest 0
  input  logic              s_axis_tlast_i,   // last_in
  // Output stream
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [ByteW-1:0]  m_axis_tdata_o,   // [7:0] byte_out
  output logic              m_axis_tlast_o,   // last_out
  output logic [TuserW-1:0] m_axis_tuser_o    // [0] run_end, [1] error
);

  logic [FmtW-1:0]   fmt_q;
  logic              dir_q;
  item_t             hold_q, hold_d;
  logic              hold_valid_q;
  pack_st_t          st_q, st_d;
  res_t              res;
  logic              out_valid_q;
  logic [ByteW-1:0]  out_data_q;
  logic              out_last_q;
  logic [TuserW-1:0] out_user_q;
  logic              out_free;
  logic              step_go;
  logic              finish;
  logic              accept;
  logic [CountW-1:0] in_count;
  logic [CountW-1:0] slots;

  lbpk_step u_step (
    .fmt_i  (fmt_q),
    .dir_i  (dir_q),
    .item_i (hold_q),
    .st_i   (st_q),
    .res_o  (res),
    .st_o   (st_d)
  );

  // Handshake control
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step_go         = hold_valid_q && (!res.emit || out_free);
  assign finish          = step_go && res.done;
  assign s_axis_tready_o = !hold_valid_q || finish;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Clamp the element count of an unpack transaction
  assign slots = fmt_slots(fmt_q);
  always_comb begin
    in_count = s_axis_tdata_i[ByteW +: CountW];
    if (in_count == '0) begin
      in_count = CountW'(1);
    end
    if (in_count > slots) begin
      in_count = slots;
    end
  end

  // Next holding-register payload
  always_comb begin
    hold_d = hold_q;
    if (accept) begin
      hold_d.byte_v = s_axis_tdata_i[ByteW-1:0];
      hold_d.last   = s_axis_tlast_i;
      hold_d.count  = in_count;
      hold_d.k      = '0;
    end else if (step_go) begin
      hold_d.k = hold_q.k + 3'd1;
    end
  end

  // Configuration registers and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q        <= FMT_ODD1;
      dir_q        <= DIR_PACK;
      st_q         <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FORMAT:    fmt_q <= cfg_data_i;
          REG_DIRECTION: dir_q <= cfg_data_i[0];
          default:       ;
        endcase
        st_q <= '0;
      end else if (step_go) begin
        st_q <= st_d;
      end

      if (accept) begin
        hold_valid_q <= 1'b1;
      end else if (finish) begin
        hold_valid_q <= 1'b0;
      end

      if (step_go && res.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold item and result
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    if (step_go && res.emit) begin
      out_data_q             <= res.data;
      out_last_q             <= res.last;
      out_user_q[UserRunEnd] <= res.run_end;
      out_user_q[UserErr]    <= res.err;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

@@ rtl/lbpk_step.sv @@
// Combinational step of the pack/unpack datapath: one element per step.
// Depends on lbpk_pkg for the item, state and result structs and the codec functions.
module lbpk_step
  import lbpk_pkg::*;
(
  input  logic [FmtW-1:0] fmt_i,
  input  logic            dir_i,
  input  item_t           item_i,
  input  pack_st_t        st_i,
  output res_t            res_o,
  output pack_st_t        st_o
);

  logic [1:0]        l2;
  logic [CountW-1:0] slots;
  enc_t              enc;
  logic [SlotW-1:0]  slot;
  logic [4:0]        pack_prod;
  logic [ByteW-1:0]  placed;
  logic [ByteW-1:0]  acc_new;
  logic              err_new;
  logic              full;
  logic [4:0]        unp_prod;
  logic [ByteW-1:0]  field;
  logic [3:0]        code;
  logic              fin;

  assign l2    = fmt_log2bits(fmt_i);
  assign slots = fmt_slots(fmt_i);

  // Pack: drop the code into its slot of the accumulator
  assign enc       = encode(fmt_i, item_i.byte_v);
  assign slot      = ({1'b0, st_i.slot} >= slots) ? '0 : st_i.slot;
  assign pack_prod = {2'b0, slot} << l2;
  assign placed    = {4'd0, enc.code} << pack_prod[2:0];
  assign acc_new   = st_i.acc | placed;
  assign err_new   = st_i.err | !enc.ok;
  assign full      = ({1'b0, slot} + 4'd1) >= slots;

  // Unpack: pick field k of the held byte
  assign unp_prod = {2'b0, item_i.k} << l2;
  assign field    = item_i.byte_v >> unp_prod[2:0];
  assign fin      = ({1'b0, item_i.k} + 4'd1) == item_i.count;

  always_comb begin
    case (l2)
      2'd0:    code = {3'd0, field[0]};
      2'd1:    code = {2'd0, field[1:0]};
      default: code = field[3:0];
    endcase
  end

  always_comb begin
    if (dir_i == DIR_PACK) begin
      res_o.emit    = full || item_i.last;
      res_o.done    = 1'b1;
      res_o.data    = acc_new;
      res_o.run_end = 1'b1;
      res_o.last    = item_i.last;
      res_o.err     = err_new;
      if (full || item_i.last) begin
        st_o = '0;
      end else begin
        st_o.acc  = acc_new;
        st_o.slot = slot + 3'd1;
        st_o.err  = err_new;
      end
    end else begin
      res_o.emit    = 1'b1;
      res_o.done    = fin;
      res_o.data    = decode(fmt_i, code);
      res_o.run_end = fin;
      res_o.last    = fin && item_i.last;
      res_o.err     = 1'b0;
      st_o          = st_i;
    end
  end

endmodule

@@ rtl/lbpk_checker.sv @@
// Port-level checker for the low-bit pack/unpack block, bound to the top level.
// Depends on lbpk_pkg and the assertion macros header.
`include "lowbit_element_pack_unpack_top_defines.svh"

module lbpk_checker
  import lbpk_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_we_i,
  input logic              cfg_idx_i,
  input logic [FmtW-1:0]   cfg_data_i,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [ByteW-1:0]  m_axis_tdata_o,
  input logic              m_axis_tlast_o,
  input logic [TuserW-1:0] m_axis_tuser_o
);

  logic dir_seen_q;

  // Track the direction register from configuration transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_seen_q <= DIR_PACK;
    end else if (cfg_we_i && (cfg_idx_i == REG_DIRECTION)) begin
      dir_seen_q <= cfg_data_i[0];
    end
  end

  `LBPK_ASSERT_NEXT(a_out_hold,
    m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) &&
      $stable(m_axis_tuser_o),
    "stalled result changed")
  `LBPK_ASSERT_HOLDS(a_last_ends_run,
    m_axis_tvalid_o && m_axis_tlast_o,
    m_axis_tuser_o[UserRunEnd],
    "last_out without run_end")
  `LBPK_ASSERT_HOLDS(a_unpack_no_err,
    m_axis_tvalid_o && (dir_seen_q == DIR_UNPACK),
    !m_axis_tuser_o[UserErr],
    "error flagged in unpack mode")
  `LBPK_ASSERT_HOLDS(a_pack_one_result,
    m_axis_tvalid_o && (dir_seen_q == DIR_PACK),
    m_axis_tuser_o[UserRunEnd],
    "packed byte without run_end")

endmodule

bind lowbit_element_pack_unpack_top lbpk_checker u_lbpk_checker (.*);
